// File: hw/rtl/rcc_pkg.sv
package rcc_pkg;

  localparam int unsigned OPND_W         = 27;
  localparam int unsigned BASE_W         = 4;
  localparam int unsigned DIGIT_W        = 4;
  localparam int unsigned MAG_W          = 56;
  localparam int unsigned CV_BITS        = 8;
  localparam int unsigned CV_STEPS       = MAG_W / CV_BITS;
  localparam int unsigned DIV_STEPS      = OPND_W;
  localparam int unsigned CNT_W          = 5;
  localparam int unsigned MAX_DIGITS_DEF = 8;

  // floor(v / 10) == (v * RECIP10) >> RECIP_SH for any 32-bit v
  localparam logic [31:0] RECIP10  = 32'hCCCC_CCCD;
  localparam int unsigned RECIP_SH = 35;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BASE  = 2'd1;
  localparam logic [1:0] ST_DIGIT = 2'd2;
  localparam logic [1:0] ST_DIVZ  = 2'd3;

  typedef struct packed {
    logic load;
    logic split;
    logic accum;
    logic exec;
    logic div_step;
    logic cv_step;
    logic emit;
    logic emit_err;
  } rcc_cmd_t;

  typedef struct packed {
    logic dec_zero;
    logic err;
    logic is_div;
    logic mag_zero;
  } rcc_stat_t;

endpackage

// File: hw/rtl/rcc_datapath.sv
module rcc_datapath #(
  parameter int unsigned MaxDigits = rcc_pkg::MAX_DIGITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [1:0]                   req_type_i,
  input  logic [rcc_pkg::OPND_W-1:0]   operand_a_i,
  input  logic [rcc_pkg::OPND_W-1:0]   operand_b_i,
  input  logic [rcc_pkg::BASE_W-1:0]   in_base_i,
  input  logic [rcc_pkg::BASE_W-1:0]   out_base_i,
  input  rcc_pkg::rcc_cmd_t            cmd_i,
  output rcc_pkg::rcc_stat_t           stat_o,
  output logic                         result_valid_o,
  output logic [1:0]                   status_o,
  output logic                         negative_o,
  output logic [rcc_pkg::DIGIT_W-1:0]  digit_o,
  output logic                         last_o
);
  import rcc_pkg::*;

  localparam int unsigned NW = $clog2(MaxDigits + 1);
  localparam int unsigned PW = OPND_W + 32;

  logic [1:0]         op_q;
  logic [BASE_W-1:0]  ib_q, ob_q;
  logic               base_bad_q, bad_q, bad_d;
  logic [OPND_W-1:0]  ra_q, rb_q, wt_q, acc_a_q, acc_b_q;
  logic [DIGIT_W-1:0] da_q, db_q;
  logic               pa_q, pb_q;
  logic [NW-1:0]      n_q;
  logic [MAG_W-1:0]   mag_q, mag_d;
  logic               neg_q;
  logic [OPND_W-1:0]  rem_q;
  logic [BASE_W-1:0]  r_q, r_d;
  logic               valid_q;
  logic [1:0]         err_code;

  logic [PW-1:0]      prod_a, prod_b;
  logic [OPND_W-1:0]  qa, qb, ra10, rb10;
  logic [DIGIT_W-1:0] da, db;
  logic               n_sat;
  logic [OPND_W:0]    div_t;
  logic               div_ge;
  logic [CV_BITS-1:0] qbits;
  logic [BASE_W:0]    cv_t;
  logic [MAG_W-1:0]   exec_mag;

  // divide by ten through the reciprocal
  always_comb begin
    prod_a = PW'(ra_q) * PW'(RECIP10);
    prod_b = PW'(rb_q) * PW'(RECIP10);
    qa     = OPND_W'(prod_a >> RECIP_SH);
    qb     = OPND_W'(prod_b >> RECIP_SH);
    ra10   = ra_q - ((qa << 3) + (qa << 1));
    rb10   = rb_q - ((qb << 3) + (qb << 1));
    da     = ra10[DIGIT_W-1:0];
    db     = rb10[DIGIT_W-1:0];
    n_sat  = (n_q >= NW'(MaxDigits));
    bad_d  = bad_q
           | ((ra_q != '0) & (n_sat | (da >= ib_q)))
           | ((rb_q != '0) & (n_sat | (db >= ib_q)));
  end

  always_comb begin
    div_t  = {rem_q, mag_q[OPND_W-1]};
    div_ge = (div_t >= {1'b0, acc_b_q});
  end

  // radix-ob long division, one byte of the magnitude per step
  always_comb begin
    r_d   = r_q;
    qbits = '0;
    cv_t  = '0;
    for (int i = 0; i < CV_BITS; i++) begin
      cv_t = {r_d, mag_q[MAG_W-1-i]};
      if (cv_t >= {1'b0, ob_q}) begin
        cv_t = cv_t - {1'b0, ob_q};
        qbits[CV_BITS-1-i] = 1'b1;
      end
      r_d = cv_t[BASE_W-1:0];
    end
    mag_d = {mag_q[MAG_W-CV_BITS-1:0], qbits};
  end

  always_comb begin
    case (op_q)
      OP_ADD:  exec_mag = MAG_W'(acc_a_q) + MAG_W'(acc_b_q);
      OP_SUB:  exec_mag = (acc_a_q >= acc_b_q) ? MAG_W'(acc_a_q - acc_b_q)
                                                : MAG_W'(acc_b_q - acc_a_q);
      OP_MUL:  exec_mag = MAG_W'(acc_a_q) * MAG_W'(acc_b_q);
      default: exec_mag = MAG_W'(acc_a_q);
    endcase
  end

  always_comb begin
    if (base_bad_q) begin
      err_code = ST_BASE;
    end else if (bad_q) begin
      err_code = ST_DIGIT;
    end else if ((op_q == OP_DIV) && (acc_b_q == '0)) begin
      err_code = ST_DIVZ;
    end else begin
      err_code = ST_OK;
    end
  end

  assign stat_o.dec_zero = (ra_q == '0) && (rb_q == '0);
  assign stat_o.err      = (err_code != ST_OK);
  assign stat_o.is_div   = (op_q == OP_DIV);
  assign stat_o.mag_zero = (mag_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.emit | cmd_i.emit_err;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q       <= req_type_i;
      ib_q       <= in_base_i;
      ob_q       <= out_base_i;
      base_bad_q <= !(in_base_i inside {[4'd2:4'd10]}) || !(out_base_i inside {[4'd2:4'd10]});
      ra_q       <= operand_a_i;
      rb_q       <= operand_b_i;
      wt_q       <= OPND_W'(1);
      acc_a_q    <= '0;
      acc_b_q    <= '0;
      n_q        <= '0;
      bad_q      <= 1'b0;
      pa_q       <= 1'b0;
      pb_q       <= 1'b0;
    end
    if (cmd_i.split) begin
      ra_q  <= qa;
      rb_q  <= qb;
      da_q  <= da;
      db_q  <= db;
      pa_q  <= (ra_q != '0);
      pb_q  <= (rb_q != '0);
      bad_q <= bad_d;
      if (!n_sat) begin
        n_q <= n_q + NW'(1);
      end
    end
    if (cmd_i.accum) begin
      if (pa_q) begin
        acc_a_q <= acc_a_q + OPND_W'(da_q * wt_q);
      end
      if (pb_q) begin
        acc_b_q <= acc_b_q + OPND_W'(db_q * wt_q);
      end
      wt_q <= OPND_W'(wt_q * ib_q);
    end
    if (cmd_i.exec) begin
      mag_q <= exec_mag;
      neg_q <= (op_q == OP_SUB) && (acc_a_q < acc_b_q);
      rem_q <= '0;
      r_q   <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= div_ge ? OPND_W'(div_t - {1'b0, acc_b_q}) : div_t[OPND_W-1:0];
      mag_q <= MAG_W'({mag_q[OPND_W-2:0], div_ge});
    end
    if (cmd_i.cv_step) begin
      mag_q <= mag_d;
      r_q   <= r_d;
    end
    if (cmd_i.emit) begin
      status_o   <= ST_OK;
      negative_o <= neg_q;
      digit_o    <= r_q;
      last_o     <= (mag_q == '0);
      r_q        <= '0;
    end
    if (cmd_i.emit_err) begin
      status_o   <= err_code;
      negative_o <= 1'b0;
      digit_o    <= '0;
      last_o     <= 1'b1;
    end
  end

  assign result_valid_o = valid_q;

endmodule

// File: hw/rtl/rcc_ctrl.sv
module rcc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  output rcc_pkg::rcc_cmd_t   cmd_o,
  input  rcc_pkg::rcc_stat_t  stat_i
);
  import rcc_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SPLIT = 4'd1;
  localparam logic [3:0] S_ACC   = 4'd2;
  localparam logic [3:0] S_CHECK = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_CONV  = 4'd5;
  localparam logic [3:0] S_EMIT  = 4'd6;
  localparam logic [3:0] S_ERR   = 4'd7;

  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);
  localparam logic [CNT_W-1:0] CV_LAST  = CNT_W'(CV_STEPS - 1);

  logic [3:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SPLIT;
        end
      end
      S_SPLIT: begin
        if (stat_i.dec_zero) begin
          state_d = S_CHECK;
        end else begin
          cmd_o.split = 1'b1;
          state_d     = S_ACC;
        end
      end
      S_ACC: begin
        cmd_o.accum = 1'b1;
        state_d     = S_SPLIT;
      end
      S_CHECK: begin
        cnt_d = '0;
        if (stat_i.err) begin
          state_d = S_ERR;
        end else begin
          cmd_o.exec = 1'b1;
          state_d    = stat_i.is_div ? S_DIV : S_CONV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + CNT_W'(1);
        if (cnt_q == DIV_LAST) begin
          cnt_d   = '0;
          state_d = S_CONV;
        end
      end
      S_CONV: begin
        cmd_o.cv_step = 1'b1;
        cnt_d         = cnt_q + CNT_W'(1);
        if (cnt_q == CV_LAST) begin
          cnt_d   = '0;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd_o.emit = 1'b1;
        state_d    = stat_i.mag_zero ? S_IDLE : S_CONV;
      end
      S_ERR: begin
        cmd_o.emit_err = 1'b1;
        state_d        = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

  a_conv_to_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CONV && cnt_q == CV_LAST) |=> (state_q == S_EMIT))
    else $error("conversion did not end in a digit beat");

  a_err_one_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ERR) |=> (state_q == S_IDLE))
    else $error("error beat not followed by idle");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.div_step, cmd_o.cv_step, cmd_o.emit, cmd_o.emit_err, cmd_o.exec}))
    else $error("conflicting datapath commands");

  a_emit_after_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> ($past(state_q) == S_CONV))
    else $error("digit beat without conversion");

endmodule

// File: hw/rtl/radix_convert_calculator_unit.sv
// sequence: a split and an accumulate step per decimal digit of the longer operand, then a decode and check;
// a divide adds a bitwise long division, then each result digit takes 7 byte steps of the base division
// and a beat in the emit state; each beat is registered and appears in the cycle after its emit state
// throughput: one item at a time, the next start is taken at the end of the last beat's cycle
// reset: asynchronous active-low to idle with the strobe low; the receiver cannot stall
module radix_convert_calculator_unit #(
  parameter int unsigned MaxDigits = rcc_pkg::MAX_DIGITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [1:0]                   req_type_i,
  input  logic [rcc_pkg::OPND_W-1:0]   operand_a_i,
  input  logic [rcc_pkg::OPND_W-1:0]   operand_b_i,
  input  logic [rcc_pkg::BASE_W-1:0]   in_base_i,
  input  logic [rcc_pkg::BASE_W-1:0]   out_base_i,
  output logic                         result_valid_o,
  output logic [1:0]                   status_o,
  output logic                         negative_o,
  output logic [rcc_pkg::DIGIT_W-1:0]  digit_o,
  output logic                         last_o
);
  import rcc_pkg::*;

  rcc_cmd_t  cmd;
  rcc_stat_t stat;

  rcc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .cmd_o   (cmd),
    .stat_i  (stat)
  );

  rcc_datapath #(
    .MaxDigits (MaxDigits)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_type_i     (req_type_i),
    .operand_a_i    (operand_a_i),
    .operand_b_i    (operand_b_i),
    .in_base_i      (in_base_i),
    .out_base_i     (out_base_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .negative_o     (negative_o),
    .digit_o        (digit_o),
    .last_o         (last_o)
  );

endmodule

// File: dv/tb_radix_convert_calculator_unit.sv
module tb_radix_convert_calculator_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import rcc_pkg::*;

  localparam int unsigned BaseMin    = 2;
  localparam int unsigned BaseMax    = 10;
  localparam int unsigned MaxDigits  = MAX_DIGITS_DEF;
  localparam int unsigned DigitLimit = 54;
  localparam int unsigned NumRandom  = 360;
  localparam int unsigned StallLimit = 3000;

  typedef struct {
    logic [1:0]        status;
    logic              negative;
    logic [DIGIT_W-1:0] digit;
    logic              last;
  } beat_t;

  typedef struct {
    logic [1:0]        op;
    logic [OPND_W-1:0] a;
    logic [OPND_W-1:0] b;
    logic [BASE_W-1:0] ib;
    logic [BASE_W-1:0] ob;
    bit                typed;
    logic [1:0]        status;
  } req_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic [1:0]         req_type_i = OP_ADD;
  logic [OPND_W-1:0]  operand_a_i = '0;
  logic [OPND_W-1:0]  operand_b_i = '0;
  logic [BASE_W-1:0]  in_base_i = 4'd10;
  logic [BASE_W-1:0]  out_base_i = 4'd10;
  logic               result_valid_o;
  logic [1:0]         status_o;
  logic               negative_o;
  logic [DIGIT_W-1:0] digit_o;
  logic               last_o;

  beat_t expected_beats[$];
  int unsigned errors = 0;
  int unsigned quiet_cycles = 0;

  radix_convert_calculator_unit DUT (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // decimal digits of v read as base-b digits
  function automatic bit read_digits(input longint unsigned v, input longint unsigned b,
                                     output longint unsigned val);
    int unsigned n;
    longint unsigned d;
    longint unsigned pw;
    n = 0;
    pw = 1;
    val = 0;
    while (v > 0) begin
      d = v % 10;
      if (n >= MaxDigits || d >= b) return 1'b0;
      val += d * pw;
      pw *= b;
      n++;
      v /= 10;
    end
    return 1'b1;
  endfunction

  function automatic beat_t err_beat(input logic [1:0] st);
    beat_t r;
    r.status = st;
    r.negative = 1'b0;
    r.digit = '0;
    r.last = 1'b1;
    return r;
  endfunction

  task automatic predict_digits(input req_t q);
    longint unsigned va, vb, mag, ob;
    logic neg;
    int unsigned k;
    beat_t r;
    neg = 1'b0;
    mag = 0;
    ob = q.ob;
    if (q.ib < BaseMin || q.ib > BaseMax || q.ob < BaseMin || q.ob > BaseMax) begin
      expected_beats.push_back(err_beat(ST_BASE));
      return;
    end
    if (!read_digits(q.a, q.ib, va) || !read_digits(q.b, q.ib, vb)) begin
      expected_beats.push_back(err_beat(ST_DIGIT));
      return;
    end
    case (q.op)
      OP_ADD: mag = va + vb;
      OP_SUB: begin
        if (va >= vb) mag = va - vb;
        else begin
          mag = vb - va;
          neg = 1'b1;
        end
      end
      OP_MUL: mag = va * vb;
      default: begin
        if (vb == 0) begin
          expected_beats.push_back(err_beat(ST_DIVZ));
          return;
        end
        mag = va / vb;
      end
    endcase
    k = 0;
    do begin
      r.status = ST_OK;
      r.negative = neg;
      r.digit = DIGIT_W'(mag % ob);
      mag /= ob;
      r.last = (mag == 0 || k == DigitLimit - 1);
      expected_beats.push_back(r);
      k++;
    end while (mag > 0 && k < DigitLimit);
  endtask

  function automatic req_t mk(input logic [1:0] op, input int unsigned a, input int unsigned b,
                              input int unsigned ib, input int unsigned ob,
                              input bit typed = 1'b0, input logic [1:0] st = ST_OK);
    req_t q;
    q.op = op;
    q.a = OPND_W'(a);
    q.b = OPND_W'(b);
    q.ib = BASE_W'(ib);
    q.ob = BASE_W'(ob);
    q.typed = typed;
    q.status = st;
    return q;
  endfunction

  // operand with random digit count, each digit valid in base ib
  function automatic int unsigned rand_operand(input int unsigned ib);
    int unsigned n, v;
    n = $urandom_range(0, MaxDigits);
    v = 0;
    repeat (n) v = v * 10 + $urandom_range(0, ib - 1);
    return v;
  endfunction

  function automatic req_t rand_req();
    req_t q;
    int unsigned ib;
    q.typed = 1'b0;
    q.status = ST_OK;
    q.op = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 99) < 12) begin
      q.a = OPND_W'($urandom);
      q.b = OPND_W'($urandom);
      q.ib = BASE_W'($urandom);
      q.ob = BASE_W'($urandom);
    end else begin
      ib = $urandom_range(BaseMin, BaseMax);
      q.ib = BASE_W'(ib);
      q.ob = BASE_W'($urandom_range(BaseMin, BaseMax));
      q.a = OPND_W'(rand_operand(ib));
      q.b = OPND_W'(rand_operand(ib));
      if ($urandom_range(0, 99) < 4) q.b = '0;
    end
    return q;
  endfunction

  task automatic send(input req_t q, input bit may_idle);
    if (may_idle) begin
      while ($urandom_range(0, 99) < 11) begin
        @(negedge clk_i);
        start_i = 1'b0;
      end
    end
    @(negedge clk_i);
    start_i = 1'b1;
    req_type_i = q.op;
    operand_a_i = q.a;
    operand_b_i = q.b;
    in_base_i = q.ib;
    out_base_i = q.ob;
    do @(posedge clk_i); while (busy_o);
    if (q.typed) expected_beats.push_back(err_beat(q.status));
    else predict_digits(q);
  endtask

  always @(posedge clk_i) begin
    beat_t e;
    if (rst_ni && result_valid_o) begin
      if (expected_beats.size() == 0) begin
        $error("unexpected beat: digit %0d last %0b", digit_o, last_o);
        errors++;
      end else begin
        e = expected_beats.pop_front();
        if (status_o !== e.status) begin
          $error("status: expected %0d actual %0d", e.status, status_o);
          errors++;
        end
        if (negative_o !== e.negative) begin
          $error("negative: expected %0b actual %0b", e.negative, negative_o);
          errors++;
        end
        if (digit_o !== e.digit) begin
          $error("digit: expected %0d actual %0d", e.digit, digit_o);
          errors++;
        end
        if (last_o !== e.last) begin
          $error("last: expected %0b actual %0b", e.last, last_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || result_valid_o || (start_i && !busy_o)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    req_t stim_table[$];
    stim_table = '{
      mk(OP_ADD, 0, 0, 10, 10),
      mk(OP_ADD, 0, 0, 0, 10, 1'b1, ST_BASE),
      mk(OP_ADD, 0, 0, 1, 10, 1'b1, ST_BASE),
      mk(OP_SUB, 0, 0, 11, 10, 1'b1, ST_BASE),
      mk(OP_MUL, 0, 0, 15, 10, 1'b1, ST_BASE),
      mk(OP_ADD, 0, 0, 10, 1, 1'b1, ST_BASE),
      mk(OP_ADD, 0, 0, 10, 11, 1'b1, ST_BASE),
      mk(OP_DIV, 5, 0, 10, 15, 1'b1, ST_BASE),
      mk(OP_ADD, 2, 1, 2, 10, 1'b1, ST_DIGIT),
      mk(OP_ADD, 1, 19, 9, 10, 1'b1, ST_DIGIT),
      mk(OP_ADD, 123456789, 1, 10, 10, 1'b1, ST_DIGIT),
      mk(OP_ADD, 1, 134217727, 10, 10, 1'b1, ST_DIGIT),
      mk(OP_DIV, 77, 0, 10, 10, 1'b1, ST_DIVZ),
      mk(OP_DIV, 0, 0, 2, 2, 1'b1, ST_DIVZ),
      mk(OP_ADD, 99999999, 99999999, 10, 10),
      mk(OP_SUB, 3, 11111111, 10, 10),
      mk(OP_SUB, 11111111, 11111111, 2, 2),
      mk(OP_SUB, 101, 1101, 2, 7),
      mk(OP_MUL, 99999999, 99999999, 10, 2),
      mk(OP_MUL, 0, 99999999, 10, 3),
      mk(OP_MUL, 11111111, 11111111, 2, 10),
      mk(OP_DIV, 99999999, 7, 10, 9),
      mk(OP_DIV, 3, 99999999, 10, 10),
      mk(OP_DIV, 10000000, 1, 2, 2)
    };
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    foreach (stim_table[i]) send(stim_table[i], 1'b1);
    for (int i = 0; i < NumRandom; i++) send(rand_req(), !(i >= 150 && i < 230));
    @(negedge clk_i);
    start_i = 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

// File: filelist.f
hw/rtl/rcc_pkg.sv
hw/rtl/rcc_datapath.sv
hw/rtl/rcc_ctrl.sv
hw/rtl/radix_convert_calculator_unit.sv
dv/tb_radix_convert_calculator_unit.sv
